// ----- design/bde_pkg.sv -----
`default_nettype none

package bde_pkg;

    // Field widths of the streaming items.
    localparam int WORD_W   = 64;
    localparam int LEN_W    = 6;
    localparam int CNT_W    = 4;
    localparam int LEFT_W   = 7;
    localparam int CELL_W   = 6;

    // Defaults for the top-level parameters.
    localparam int MAX_EDITS_DEF  = 8;
    localparam int WORD_BASES_DEF = 32;

    // Reset value of the edit limit register.
    localparam logic [CNT_W-1:0] MAX_EDITS_RST = 4'd3;

    // One job after masking and length clamping.
    typedef struct packed {
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w2;
        logic [LEN_W-1:0]  l1;
        logic [LEN_W-1:0]  l2;
        logic              left;
    } job_t;

    // One band cell: matched total and bases used from each word.
    typedef struct packed {
        logic [CELL_W-1:0] t;
        logic [CELL_W-1:0] u1;
        logic [CELL_W-1:0] u2;
    } cell_t;

    // Request to the match-run unit.
    typedef struct packed {
        logic [CELL_W-1:0]        u1;
        logic [CELL_W-1:0]        u2;
        logic signed [LEFT_W-1:0] r1;
        logic signed [LEFT_W-1:0] r2;
    } mreq_t;

    // Result of one job.
    typedef struct packed {
        logic [CNT_W-1:0]         edit_count;
        logic signed [LEFT_W-1:0] w1_left;
    } result_t;

endpackage

`default_nettype wire

// ----- design/banded_dna_edit_distance_unit.sv -----
// Banded DNA edit distance unit.
// Input channel s_*: one transfer carries two 2-bit packed words of up to 32
// bases with their lengths; s_tuser selects left (MSB) or right (LSB) packing.
// Output channel m_*: one transfer per input carries the edit count and the
// number of first-word bases left unmatched (-1 when no alignment was found).
// Register max_edits is written through max_edits_we / max_edits_wdata while
// the unit is idle; the user must keep to this, as the unit does not enforce it.
// It resets to 3 and values above MAX_EDITS act as MAX_EDITS. Equal words and
// over-long length gaps are settled by the length check alone. Otherwise the
// length check is followed by row zero and then by each band cell in turn (band
// read, neighbor select, shift and compare, zero count); row zero skips the read
// and select. Rows 1 to max_edits+1 hold (max_edits+1)*(max_edits+3) cells, each
// through the shared match-run unit and single band memory read port in turn,
// ending early at the first cell past row zero that finishes the second word.
// One item is processed at a time; s_tready is low while it runs. A finished
// result waits in the output register while m_tready is low, and the next
// input can be taken meanwhile; a second finished result then holds the
// sequencer and s_tready stays low. Reset clears all control state and empties
// the output register.
`default_nettype none

module banded_dna_edit_distance_unit
    import bde_pkg::*;
#(
    parameter int MAX_EDITS  = MAX_EDITS_DEF,
    parameter int WORD_BASES = WORD_BASES_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // Configuration write.
    input  wire logic             max_edits_we,
    input  wire logic [CNT_W-1:0] max_edits_wdata,
    // Input stream.
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // w1_bases[63:0], w1_len[69:64], w2_bases[133:70], w2_len[139:134], zero fill
    input  wire logic [143:0]     s_tdata,
    // msb_align[0]
    input  wire logic             s_tuser,
    // Output stream.
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // edit_count[3:0], w1_left[10:4], zero fill
    output logic [15:0]           m_tdata
);

    localparam int SH_W = LEN_W + 1;

    logic [CNT_W-1:0] max_edits_reg;
    job_t             job_reg;
    job_t             job_in;
    logic             m_tvalid_reg;
    result_t          out_reg;
    logic             seq_idle;
    logic             seq_done;
    result_t          seq_res;
    logic             ack;
    logic             s_xfer;

    // Clamp a length to the word size.
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        if (SH_W'(len) > SH_W'(WORD_BASES))
            return LEN_W'(WORD_BASES);
        return len;
    endfunction

    // Clear the bits beyond a word's length.
    function automatic logic [WORD_W-1:0] mask_word(input logic [WORD_W-1:0] w,
                                                    input logic [LEN_W-1:0] len,
                                                    input logic left);
        logic [SH_W:0] keep;
        keep = {1'b0, len, 1'b0};
        if (len == '0)
            return '0;
        if (len >= LEN_W'(32))
            return w;
        if (left)
            return w & ({WORD_W{1'b1}} << ((SH_W+1)'(WORD_W) - keep));
        return w & ~({WORD_W{1'b1}} << keep);
    endfunction

    // Unpack and mask the incoming item.
    always_comb
    begin
        job_in.l1   = clamp_len(s_tdata[69:64]);
        job_in.l2   = clamp_len(s_tdata[139:134]);
        job_in.left = s_tuser;
        job_in.w1   = mask_word(s_tdata[63:0], job_in.l1, s_tuser);
        job_in.w2   = mask_word(s_tdata[133:70], job_in.l2, s_tuser);
    end

    assign s_tready = seq_idle;
    assign s_xfer   = s_tvalid && s_tready;
    assign ack      = seq_done && (!m_tvalid_reg || m_tready);

    bde_seq #(
        .MAX_EDITS (MAX_EDITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_xfer),
        .job       (job_reg),
        .max_edits (max_edits_reg),
        .ack       (ack),
        .idle      (seq_idle),
        .done      (seq_done),
        .res       (seq_res)
    );

    // Configuration register and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_edits_reg <= MAX_EDITS_RST;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (max_edits_we)
                max_edits_reg <= max_edits_wdata;
            if (ack)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Job and result payload registers.
    always_ff @(posedge clk)
    begin
        if (s_xfer)
            job_reg <= job_in;
        if (ack)
            out_reg <= seq_res;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, out_reg.w1_left, out_reg.edit_count};

endmodule

`default_nettype wire

// ----- design/bde_match.sv -----
`default_nettype none

// Match-run unit: shifts both words past the used bases, compares them and
// counts the equal base pairs from the aligned end. The shift and
// compare are registered, the zero count is combinational from that register.
module bde_match
    import bde_pkg::*;
(
    input  wire logic                clk,
    input  wire logic [WORD_W-1:0]   w1,
    input  wire logic [WORD_W-1:0]   w2,
    input  wire logic                left,
    input  wire mreq_t               req,
    output logic [CELL_W-1:0]        run
);

    localparam int SH_W = CELL_W + 1;

    logic [WORD_W-1:0] s1;
    logic [WORD_W-1:0] s2;
    logic [SH_W-1:0]   sh1;
    logic [SH_W-1:0]   sh2;
    logic              none;
    logic [CELL_W-1:0] lim;

    logic [WORD_W-1:0] x_reg;
    logic [CELL_W-1:0] lim_reg;
    logic              none_reg;
    logic              left_reg;

    logic [WORD_W-1:0] xr;
    logic [SH_W-1:0]   tz;
    logic [CELL_W-1:0] k;

    // Shift both words by the bases already used.
    always_comb
    begin
        sh1 = {req.u1, 1'b0};
        sh2 = {req.u2, 1'b0};
        if (req.u1 >= CELL_W'(32))
            s1 = '0;
        else if (left)
            s1 = w1 << sh1;
        else
            s1 = w1 >> sh1;
        if (req.u2 >= CELL_W'(32))
            s2 = '0;
        else if (left)
            s2 = w2 << sh2;
        else
            s2 = w2 >> sh2;
        none = (req.r1 <= 0) || (req.r2 <= 0);
        if (req.r1 < req.r2)
            lim = req.r1[CELL_W-1:0];
        else
            lim = req.r2[CELL_W-1:0];
    end

    // Compare stage register.
    always_ff @(posedge clk)
    begin
        x_reg    <= s1 ^ s2;
        lim_reg  <= lim;
        none_reg <= none;
        left_reg <= left;
    end

    // Count equal pairs from the aligned end.
    always_comb
    begin
        for (int i = 0; i < WORD_W; i++)
        begin
            xr[i] = left_reg ? x_reg[WORD_W-1-i] : x_reg[i];
        end
        tz = SH_W'(WORD_W);
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (xr[i])
                tz = SH_W'(i);
        end
        k = tz[SH_W-1:1];
        if (none_reg)
            run = '0;
        else if (x_reg == '0)
            run = lim_reg;
        else if (k < lim_reg)
            run = k;
        else
            run = lim_reg;
    end

endmodule

`default_nettype wire

// ----- design/bde_seq.sv -----
`default_nettype none

// Band sequencer: walks the diagonal band one cell at a time, keeps the
// previous and current rows in a small two-row memory and feeds the shared
// match-run unit.
module bde_seq
    import bde_pkg::*;
#(
    parameter int MAX_EDITS = MAX_EDITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire job_t             job,
    input  wire logic [CNT_W-1:0] max_edits,
    input  wire logic             ack,
    output logic                  idle,
    output logic                  done,
    output result_t               res
);

    localparam int D_W   = $clog2(MAX_EDITS + 2);
    localparam int COLS  = 2 * MAX_EDITS + 3;
    localparam int CW    = $clog2(COLS);
    localparam int DEPTH = 2 ** (CW + 1);
    localparam int CMP_W = 8;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_DAT  = 3'd3;
    localparam logic [2:0] S_M1   = 3'd4;
    localparam logic [2:0] S_M2   = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [D_W-1:0]    d_reg, d_next;
    logic [CW-1:0]     c_reg, c_next;
    logic [D_W-1:0]    md_reg, md_next;
    logic [CW-1:0]     center_reg, center_next;
    logic [LEN_W-1:0]  short_reg, short_next;
    cell_t             a_reg, a_next, b_reg, b_next, nx_reg, nx_next;
    logic              av_reg, av_next, bv_reg, bv_next, nxv_reg, nxv_next;
    cell_t             cur_reg, cur_next;
    result_t           res_reg, res_next;

    cell_t             mem [DEPTH];
    cell_t             rdata_reg;
    logic              wr_en;
    logic [CW:0]       wr_addr;
    logic              rd_en;
    logic [CW:0]       rd_addr;
    cell_t             wr_cell;

    mreq_t             req;
    logic [CELL_W-1:0] run;

    logic [D_W-1:0]    md_c;
    logic [LEN_W-1:0]  gap;
    logic              last_col;
    logic [CELL_W-1:0] tn, u1n, u2n;
    logic signed [LEFT_W-1:0] r1n, r2n;
    logic              fin;
    cell_t             sel;
    logic              have;
    logic [CW-1:0]     c_start;

    // Shared match-run unit.
    bde_match u_match
    (
        .clk  (clk),
        .w1   (job.w1),
        .w2   (job.w2),
        .left (job.left),
        .req  (req),
        .run  (run)
    );

    always_comb
    begin
        req.u1 = cur_reg.u1;
        req.u2 = cur_reg.u2;
        req.r1 = LEFT_W'(job.l1) - LEFT_W'(cur_reg.u1);
        req.r2 = LEFT_W'(job.l2) - LEFT_W'(cur_reg.u2);
    end

    // Two-row band memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_cell;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    // Values derived for the current cell.
    always_comb
    begin
        if (CMP_W'(max_edits) > CMP_W'(MAX_EDITS))
            md_c = D_W'(MAX_EDITS);
        else
            md_c = D_W'(max_edits);
        if (job.l1 > job.l2)
            gap = job.l1 - job.l2;
        else
            gap = job.l2 - job.l1;

        tn  = cur_reg.t + run;
        u1n = cur_reg.u1 + run;
        u2n = cur_reg.u2 + run;
        r1n = LEFT_W'(job.l1) - LEFT_W'(u1n);
        r2n = LEFT_W'(job.l2) - LEFT_W'(u2n);
        fin = (d_reg != '0) && (r2n <= 0)
              && (CMP_W'(tn) + CMP_W'(d_reg) >= CMP_W'(short_reg));
        last_col = (CMP_W'(c_reg) == CMP_W'(center_reg) + CMP_W'(d_reg));
        c_start  = CW'(CMP_W'(center_reg) - CMP_W'(d_reg) - CMP_W'(1));

        // Best neighbor of the row above.
        have = 1'b0;
        sel  = '0;
        if (bv_reg)
        begin
            sel.t  = b_reg.t;
            sel.u1 = b_reg.u1 + CELL_W'(1);
            sel.u2 = b_reg.u2 + CELL_W'(1);
            have   = 1'b1;
        end
        if (av_reg && (!have || a_reg.t > sel.t))
        begin
            sel.t  = a_reg.t;
            sel.u1 = a_reg.u1 + CELL_W'(1);
            sel.u2 = a_reg.u2;
            have   = 1'b1;
        end
        if (nxv_reg && (!have || rdata_reg.t > sel.t))
        begin
            sel.t  = rdata_reg.t;
            sel.u1 = rdata_reg.u1;
            sel.u2 = rdata_reg.u2 + CELL_W'(1);
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        d_next      = d_reg;
        c_next      = c_reg;
        md_next     = md_reg;
        center_next = center_reg;
        short_next  = short_reg;
        a_next      = a_reg;
        av_next     = av_reg;
        b_next      = b_reg;
        bv_next     = bv_reg;
        nx_next     = nx_reg;
        nxv_next    = nxv_reg;
        cur_next    = cur_reg;
        res_next    = res_reg;
        wr_en       = 1'b0;
        wr_addr     = {d_reg[0], c_reg};
        wr_cell     = '{t: tn, u1: u1n, u2: u2n};
        rd_en       = 1'b0;
        rd_addr     = {~d_reg[0], CW'(CMP_W'(c_reg) + CMP_W'(1))};

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                md_next     = md_c;
                center_next = CW'(CMP_W'(md_c) + CMP_W'(1));
                short_next  = (job.l1 < job.l2) ? job.l1 : job.l2;
                d_next      = '0;
                c_next      = CW'(CMP_W'(md_c) + CMP_W'(1));
                cur_next    = '0;
                if (job.w1 == job.w2 && job.l1 == job.l2)
                begin
                    res_next   = '{edit_count: '0, w1_left: '0};
                    state_next = S_DONE;
                end
                else if (CMP_W'(gap) > CMP_W'(md_c))
                begin
                    res_next.edit_count = CNT_W'(CMP_W'(md_c) + CMP_W'(1));
                    res_next.w1_left    = -LEFT_W'(1);
                    state_next          = S_DONE;
                end
                else
                    state_next = S_M1;
            end
            S_RD:
            begin
                // The next column is in the row above's band unless at its end.
                nxv_next = (CMP_W'(c_reg) + CMP_W'(1)
                            < CMP_W'(center_reg) + CMP_W'(d_reg));
                rd_en    = 1'b1;
                state_next = S_DAT;
            end
            S_DAT:
            begin
                nx_next    = rdata_reg;
                cur_next   = sel;
                state_next = S_M1;
            end
            S_M1:
            begin
                state_next = S_M2;
            end
            S_M2:
            begin
                wr_en = 1'b1;
                if (fin)
                begin
                    res_next.edit_count = CNT_W'(d_reg);
                    res_next.w1_left    = r1n;
                    state_next          = S_DONE;
                end
                else if (d_reg == '0 || last_col)
                begin
                    if (CMP_W'(d_reg) == CMP_W'(md_reg) + CMP_W'(1))
                    begin
                        res_next.edit_count = CNT_W'(CMP_W'(md_reg) + CMP_W'(1));
                        res_next.w1_left    = -LEFT_W'(1);
                        state_next          = S_DONE;
                    end
                    else
                    begin
                        d_next     = d_reg + D_W'(1);
                        c_next     = c_start;
                        av_next    = 1'b0;
                        bv_next    = 1'b0;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    c_next     = c_reg + CW'(1);
                    a_next     = b_reg;
                    av_next    = bv_reg;
                    b_next     = nx_reg;
                    bv_next    = nxv_reg;
                    state_next = S_RD;
                end
            end
            S_DONE:
            begin
                if (ack)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            av_reg    <= 1'b0;
            bv_reg    <= 1'b0;
            nxv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            av_reg    <= av_next;
            bv_reg    <= bv_next;
            nxv_reg   <= nxv_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        d_reg      <= d_next;
        c_reg      <= c_next;
        md_reg     <= md_next;
        center_reg <= center_next;
        short_reg  <= short_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        nx_reg     <= nx_next;
        cur_reg    <= cur_next;
        res_reg    <= res_next;
    end

    assign idle = (state_reg == S_IDLE);
    assign done = (state_reg == S_DONE);
    assign res  = res_reg;

endmodule

`default_nettype wire
